@@ src/ccrf_pkg.sv @@
// Shared types and constants for the contact repulsion force unit.
package ccrf_pkg;

  localparam int PosW = 32;
  localparam int RadW = 31;
  localparam int FacW = 24;
  localparam int OutW = 48;
  localparam logic [FacW-1:0] FacReset = 24'd4096;

  typedef struct packed {
    logic signed [PosW-1:0] own_x;
    logic signed [PosW-1:0] own_y;
    logic signed [PosW-1:0] own_z;
    logic [RadW-1:0]        own_radius;
    logic signed [PosW-1:0] neighbor_x;
    logic signed [PosW-1:0] neighbor_y;
    logic signed [PosW-1:0] neighbor_z;
    logic [RadW-1:0]        neighbor_radius;
    logic                   neighbor_present;
    logic                   last_neighbor;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] force_x;
    logic signed [OutW-1:0] force_y;
    logic signed [OutW-1:0] force_z;
  } out_t;

endpackage

@@ src/ccrf_mul.sv @@
// Shared 32x32 unsigned multiplier.
module ccrf_mul import ccrf_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  assign p = 64'(a) * 64'(b);
endmodule

@@ src/cell_contact_repulsion_force_unit.sv @@
// Top level of the contact repulsion force unit.
//
// Input channel (in_valid / in_stall / in_data): one word per neighbor of a
// target cell. A word with neighbor_present clear adds nothing; the word
// with last_neighbor set closes the run and produces one force word.
// Output channel (out_valid / out_stall / out_data): the scaled force,
// saturated to 48 bits per component.
// Configuration: cfg_we / cfg_data write repulsion_factor (Q12.12).
//
// Every word runs through a small sequencer around one shared 32x32
// multiplier and one 64-bit compare/subtract path. A neighbor in contact
// holds in_stall through one range check, 3 squares, one bound check,
// 32 square-root steps (one result bit a cycle), 16 division steps, one
// weight multiply, three accumulate steps and one closing step. A word
// without contact holds it up to the failing check and the closing step.
// A closing word adds the multiplies for the output scaling.
// The force word sits in an output register; new input words are taken
// while it waits. A closing word holds before scaling until the previous
// force word has left. Reset (rst, synchronous) clears the running sums,
// the output valid and loads repulsion_factor with 1.0.
module cell_contact_repulsion_force_unit import ccrf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_t                out_data,
  input  logic                cfg_we,
  input  logic [FacW-1:0]     cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_WGT   = 4'd6;
  localparam logic [3:0] S_APPLY = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]             st;
  logic [1:0]             idx;
  logic                   phase;
  logic [4:0]             k;
  logic [3:0]             cnt;
  logic                   last;
  logic [FacW-1:0]        fac;
  logic signed [32:0]     dreg [3];
  logic [32:0]            areg [3];
  logic [31:0]            s;
  logic [63:0]            d2;
  logic [63:0]            n;
  logic [63:0]            res;
  logic [31:0]            rem;
  logic [15:0]            q;
  logic [16:0]            w;
  logic [47:0]            plo;
  logic signed [OutW-1:0] sum [3];
  logic signed [OutW-1:0] fo [3];

  logic [31:0] ma, mb;
  logic [63:0] prod;

  ccrf_mul u_mul (.a(ma), .b(mb), .p(prod));

  // Working values of the current step
  logic [16:0]            t;
  logic [47:0]            mag;
  logic [63:0]            bitv;
  logic [63:0]            rb;
  logic [64:0]            d2_next;
  logic [32:0]            r2;
  logic                   ge;
  logic signed [48:0]     acc;
  logic signed [OutW-1:0] acc_sat;
  logic [71:0]            full;
  logic [59:0]            r;
  logic signed [OutW-1:0] scaled;
  logic signed [32:0]     d_in [3];

  assign t    = 17'd65536 - {1'b0, q};
  assign mag  = sum[idx][OutW-1] ? 48'(-sum[idx]) : 48'(sum[idx]);
  assign bitv = 64'd1 << {k, 1'b0};
  assign rb   = res + bitv;
  assign d2_next = {1'b0, d2} + {1'b0, prod};
  assign r2   = {rem, 1'b0};
  assign ge   = r2 >= {1'b0, s};
  assign full = (72'(prod) << 24) + 72'(plo);
  assign r    = full[71:12];

  assign d_in[0] = 33'(in_data.own_x) - 33'(in_data.neighbor_x);
  assign d_in[1] = 33'(in_data.own_y) - 33'(in_data.neighbor_y);
  assign d_in[2] = 33'(in_data.own_z) - 33'(in_data.neighbor_z);

  always_comb begin
    ma = areg[idx][31:0];
    mb = areg[idx][31:0];
    case (st)
      S_CMP: begin
        ma = s;
        mb = s;
      end
      S_WGT: begin
        ma = 32'(t);
        mb = 32'(t);
      end
      S_APPLY: begin
        mb = 32'(w);
      end
      S_EMIT: begin
        ma = phase ? 32'(mag[47:24]) : 32'(mag[23:0]);
        mb = 32'(fac);
      end
      default: ;
    endcase
  end

  // Accumulate one signed contribution with saturation
  always_comb begin
    if (dreg[idx][32]) begin
      acc = 49'(sum[idx]) - 49'(prod[47:16]);
    end else begin
      acc = 49'(sum[idx]) + 49'(prod[47:16]);
    end
    if (acc > 49'sh7FFF_FFFF_FFFF) begin
      acc_sat = 48'sh7FFF_FFFF_FFFF;
    end else if (acc < -49'sh8000_0000_0000) begin
      acc_sat = 48'sh8000_0000_0000;
    end else begin
      acc_sat = acc[47:0];
    end
  end

  // Apply sign and clamp the scaled magnitude
  always_comb begin
    if (sum[idx][OutW-1]) begin
      scaled = (r >= 60'h8000_0000_0000) ? 48'sh8000_0000_0000 : 48'(-r);
    end else begin
      scaled = (r > 60'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : 48'(r);
    end
  end

  assign in_stall = (st != S_IDLE);
  assign out_data.force_x = fo[0];
  assign out_data.force_y = fo[1];
  assign out_data.force_z = fo[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      fac       <= FacReset;
      idx       <= '0;
      phase     <= 1'b0;
      for (int i = 0; i < 3; i++) sum[i] <= '0;
    end else begin
      if (cfg_we) fac <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            last <= in_data.last_neighbor;
            s    <= 32'(in_data.own_radius) + 32'(in_data.neighbor_radius);
            for (int i = 0; i < 3; i++) begin
              dreg[i] <= d_in[i];
              areg[i] <= d_in[i][32] ? 33'(-d_in[i]) : 33'(d_in[i]);
            end
            st <= in_data.neighbor_present ? S_CHK : S_FIN;
          end
        end
        S_CHK: begin
          // Drop the neighbor on a zero radius sum or a distant component
          if (s == '0 || areg[0] >= 33'(s) || areg[1] >= 33'(s) || areg[2] >= 33'(s)) begin
            st <= S_FIN;
          end else begin
            idx <= '0;
            d2  <= '0;
            st  <= S_SQ;
          end
        end
        S_SQ: begin
          if (d2_next[64]) begin
            st <= S_FIN;
          end else begin
            d2 <= d2_next[63:0];
            if (idx == 2'd2) begin
              st <= S_CMP;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        S_CMP: begin
          if (d2 < prod) begin
            n   <= d2;
            res <= '0;
            k   <= 5'd31;
            st  <= S_SQRT;
          end else begin
            st <= S_FIN;
          end
        end
        S_SQRT: begin
          if (n >= rb) begin
            n   <= n - rb;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          if (k == '0) begin
            // Load the division remainder with the finished root
            rem <= (n >= rb) ? 32'((res >> 1) + bitv) : 32'(res >> 1);
            q   <= '0;
            st  <= S_DIV;
            cnt <= 4'd15;
          end else begin
            k <= k - 5'd1;
          end
        end
        S_DIV: begin
          rem <= ge ? 32'(r2 - {1'b0, s}) : r2[31:0];
          q   <= {q[14:0], ge};
          if (cnt == '0) begin
            st <= S_WGT;
          end
          cnt <= cnt - 4'd1;
        end
        S_WGT: begin
          w   <= prod[32:16];
          idx <= '0;
          st  <= S_APPLY;
        end
        S_APPLY: begin
          sum[idx] <= acc_sat;
          if (idx == 2'd2) begin
            st <= S_FIN;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_FIN: begin
          if (!last) begin
            st <= S_IDLE;
          end else if (!out_valid || !out_stall) begin
            idx   <= '0;
            phase <= 1'b0;
            st    <= S_EMIT;
          end
        end
        S_EMIT: begin
          phase <= !phase;
          if (!phase) begin
            plo <= prod[47:0];
          end else begin
            fo[idx] <= scaled;
            if (idx == 2'd2) begin
              for (int i = 0; i < 3; i++) sum[i] <= '0;
              out_valid <= 1'b1;
              st        <= S_IDLE;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/ccrf_checker.sv @@
// Port-level checks for the contact repulsion force unit, with its bind.
module ccrf_checker import ccrf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled force word changed");

  a_idle_between_results: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("force word repeated");

endmodule

bind cell_contact_repulsion_force_unit ccrf_checker u_ccrf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
